// ===== src/wsd_pkg.sv =====
// shared types and constants for the websocket frame deframer
package wsd_pkg;

  // width of the payload_length field on the result word
  localparam int LEN_FIELD_W = 64;

  // header_position value that marks the payload phase
  localparam logic [3:0] PAYLOAD_PHASE = 4'd15;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_HEADER  = 3'd1;
  localparam logic [2:0] KIND_PING    = 3'd2;
  localparam logic [2:0] KIND_PONG    = 3'd3;
  localparam logic [2:0] KIND_CLOSE   = 3'd4;
  localparam logic [2:0] KIND_BAD_OP  = 3'd5;

  // opcodes of byte zero
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'ha;

  // length forms of byte one
  localparam logic [1:0] FORM_SHORT = 2'd0;
  localparam logic [1:0] FORM_EXT16 = 2'd1;
  localparam logic [1:0] FORM_EXT64 = 2'd2;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  localparam logic [1:0] FRAME_TEXT = 2'd1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [7:0]             data_byte;
    logic                   last_flag;
    logic                   final_fragment;
    logic [1:0]             frame_type;
    logic                   masked;
    logic [LEN_FIELD_W-1:0] payload_length;
  } out_word_t;

endpackage

// ===== src/websocket_frame_deframer.sv =====
// Top level: websocket frame deframer, one frame byte per input word.
// Takes one input word every clock while in_stall is low and gives at most one result
// word per input word, registered in the result register or, under output stall, the
// skid entry. Header decode, length accumulation and unmasking are combinational from
// the parser state registers to the result register: one byte per cycle unless stalled.
// A two-entry result stage (result register plus skid entry) lets the input side keep
// going for one word while the output is stalled; in_stall rises once the skid entry
// holds a word. Decoded lengths beyond LENGTH_WIDTH bits saturate to all ones.
module websocket_frame_deframer #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wsd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wsd_pkg::out_word_t out_data
);

  logic               acc;
  logic               res_valid;
  wsd_pkg::out_word_t res_word;
  logic               full;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  wsd_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_word  (in_data),
    .res_valid(res_valid),
    .res_word (res_word)
  );

  wsd_out_skid u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_word(res_word),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== src/wsd_parser.sv =====
// header decode, length accumulation and text-frame payload unmasking, one byte per cycle when acc is high
module wsd_parser #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  wsd_pkg::in_word_t  in_word,
  output logic               res_valid,
  output wsd_pkg::out_word_t res_word
);

  localparam int LenFieldW = wsd_pkg::LEN_FIELD_W;

  logic                    ignoring_r, ignoring_nxt;
  logic [3:0]              hp_r, hp_nxt;
  logic [1:0]              kind_r, kind_nxt;
  logic                    fin_r, fin_nxt;
  logic                    mask_r, mask_nxt;
  logic [1:0]              form_r, form_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [31:0]             key_r, key_nxt;
  logic [LENGTH_WIDTH-1:0] pos_r, pos_nxt;

  logic [7:0]              b;
  logic [3:0]              op;
  logic [3:0]              ext;
  logic [3:0]              total;
  logic [3:0]              hp_inc;
  logic [1:0]              key_idx;
  logic [LENGTH_WIDTH+7:0] shifted;
  logic [LENGTH_WIDTH-1:0] pos_inc;
  logic [LENGTH_WIDTH-1:0] len_sat;
  logic                    finish;

  assign b  = in_word.in_byte;
  assign op = in_word.in_byte[3:0];

  always_comb begin
    ignoring_nxt = ignoring_r;
    hp_nxt       = hp_r;
    kind_nxt     = kind_r;
    fin_nxt      = fin_r;
    mask_nxt     = mask_r;
    form_nxt     = form_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    key_nxt      = key_r;
    pos_nxt      = pos_r;
    res_valid    = 1'b0;
    res_word     = '0;
    finish       = 1'b0;
    len_sat      = '0;

    unique case (form_r)
      wsd_pkg::FORM_EXT16: ext = 4'd2;
      wsd_pkg::FORM_EXT64: ext = 4'd8;
      default:             ext = 4'd0;
    endcase
    total   = 4'd2 + ext + (mask_r ? 4'd4 : 4'd0);
    hp_inc  = hp_r + 4'd1;
    key_idx = 2'(hp_r - 4'd2 - ext);
    shifted = {len_r, b};
    pos_inc = pos_r + LENGTH_WIDTH'(1);

    if (acc) begin
      priority if (in_word.frame_start) begin
        // a start restarts the parser whatever it was doing
        ignoring_nxt = 1'b0;
        hp_nxt       = '0;
        kind_nxt     = '0;
        fin_nxt      = b[7];
        mask_nxt     = 1'b0;
        form_nxt     = wsd_pkg::FORM_SHORT;
        len_nxt      = '0;
        ovf_nxt      = 1'b0;
        key_nxt      = '0;
        pos_nxt      = '0;
        if (op <= wsd_pkg::OP_BINARY) begin
          kind_nxt = op[1:0];
          hp_nxt   = 4'd1;
        end else begin
          ignoring_nxt            = 1'b1;
          res_valid               = 1'b1;
          res_word.final_fragment = b[7];
          priority if (op == wsd_pkg::OP_PING)       res_word.kind = wsd_pkg::KIND_PING;
          else if (op == wsd_pkg::OP_PONG)           res_word.kind = wsd_pkg::KIND_PONG;
          else if (op == wsd_pkg::OP_CLOSE)          res_word.kind = wsd_pkg::KIND_CLOSE;
          else                                       res_word.kind = wsd_pkg::KIND_BAD_OP;
        end
      end else if (ignoring_r) begin
        ignoring_nxt = 1'b1;
      end else if (hp_r == wsd_pkg::PAYLOAD_PHASE) begin
        res_valid               = 1'b1;
        res_word.kind           = wsd_pkg::KIND_PAYLOAD;
        res_word.data_byte      = (mask_r && kind_r == wsd_pkg::FRAME_TEXT)
                                  ? (b ^ key_r[{pos_r[1:0], 3'b000} +: 8]) : b;
        res_word.last_flag      = (pos_inc >= len_r);
        res_word.final_fragment = fin_r;
        res_word.frame_type     = kind_r;
        res_word.masked         = mask_r;
        res_word.payload_length = LenFieldW'(len_r);
        pos_nxt                 = pos_inc;
        if (pos_inc >= len_r) begin
          ignoring_nxt = 1'b1;
        end
      end else if (hp_r == 4'd1) begin
        mask_nxt = b[7];
        hp_nxt   = 4'd2;
        priority if (b[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
          form_nxt = wsd_pkg::FORM_EXT64;
        end else if (b[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
          form_nxt = wsd_pkg::FORM_EXT16;
        end else begin
          form_nxt = wsd_pkg::FORM_SHORT;
          len_nxt  = LENGTH_WIDTH'(b[6:0]);
          finish   = !b[7];
        end
      end else if (hp_r >= 4'd2) begin
        if (hp_r < 4'd2 + ext) begin
          // bits pushed past the length width make the length saturate
          len_nxt = shifted[LENGTH_WIDTH-1:0];
          ovf_nxt = ovf_r | (|shifted[LENGTH_WIDTH+7:LENGTH_WIDTH]);
        end else begin
          key_nxt[{key_idx, 3'b000} +: 8] = b;
        end
        hp_nxt = hp_inc;
        finish = (hp_inc >= total);
      end else begin
        ignoring_nxt = 1'b1;
      end
    end

    if (finish) begin
      len_sat                 = ovf_nxt ? '1 : len_nxt;
      len_nxt                 = len_sat;
      res_valid               = 1'b1;
      res_word.kind           = wsd_pkg::KIND_HEADER;
      res_word.last_flag      = (len_sat == '0);
      res_word.final_fragment = fin_nxt;
      res_word.frame_type     = kind_nxt;
      res_word.masked         = mask_nxt;
      res_word.payload_length = LenFieldW'(len_sat);
      if (len_sat == '0) begin
        ignoring_nxt = 1'b1;
      end else begin
        hp_nxt  = wsd_pkg::PAYLOAD_PHASE;
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignoring_r <= 1'b1;
      hp_r       <= '0;
    end else begin
      ignoring_r <= ignoring_nxt;
      hp_r       <= hp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    fin_r  <= fin_nxt;
    mask_r <= mask_nxt;
    form_r <= form_nxt;
    len_r  <= len_nxt;
    ovf_r  <= ovf_nxt;
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
  end

  a_active_has_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !ignoring_r |-> hp_r != 4'd0)
    else $error("parser active with header position zero");

  a_payload_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!ignoring_r && hp_r == wsd_pkg::PAYLOAD_PHASE) |-> len_r != '0)
    else $error("payload phase entered with zero length");

  a_payload_pos_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!ignoring_r && hp_r == wsd_pkg::PAYLOAD_PHASE) |-> pos_r < len_r)
    else $error("payload position reached length while still active");

endmodule

// ===== src/wsd_out_skid.sv =====
// result register with one skid entry so input keeps flowing for one word under output stall
module wsd_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wsd_pkg::out_word_t push_word,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output wsd_pkg::out_word_t out_data
);

  logic               main_valid_r, main_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  wsd_pkg::out_word_t main_r, main_nxt;
  wsd_pkg::out_word_t skid_r, skid_nxt;
  logic               pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // input is held off while the skid entry is in use
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_word;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_word;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held with empty result register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && skid_valid_r))
    else $error("word pushed while skid entry in use");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && skid_valid_r) |=> (main_valid_r && !skid_valid_r))
    else $error("skid entry not moved into result register on pop");

endmodule
